// File: design/skt_pkg.sv
package skt_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Per-transfer strobes broadcast to every cell of the row.
  typedef struct packed {
    logic ins;  // insert that fits
    logic rem;  // remove at a valid rank
    logic tap;  // lookup or remove: sample the selected key
  } skt_ctrl_t;

endpackage

// File: design/skt_cell.sv
module skt_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 9
) (
  input  logic              clk,
  input  skt_pkg::skt_ctrl_t ctrl,
  input  skt_pkg::key_t     key,
  input  skt_pkg::idx_t     index,
  input  logic [CW-1:0]     fill,
  input  skt_pkg::key_t     left_entry,
  input  logic              left_less,
  input  skt_pkg::key_t     right_entry,
  output skt_pkg::key_t     entry,
  output logic              less,
  output skt_pkg::key_t     tap
);
  import skt_pkg::*;

  logic occupied;
  logic hit;
  logic at_or_after;

  assign occupied    = fill > CW'(INDEX);
  assign less        = occupied && (entry < key);
  assign hit         = 32'(index) == 32'(INDEX);
  assign at_or_after = 32'(index) <= 32'(INDEX);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      // Cells holding smaller keys stay; the first other cell takes the new
      // key and every cell after it takes its left neighbor's key.
      if (!less) begin
        if (left_less) begin
          entry <= key;
        end else begin
          entry <= left_entry;
        end
      end
    end else if (ctrl.rem && at_or_after) begin
      entry <= right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tap) begin
      tap <= hit ? entry : '0;
    end
  end

endmodule

// File: design/skt_or_tree.sv
module skt_or_tree #(
  parameter int LEAVES = 256
) (
  input  logic          clk,
  input  skt_pkg::key_t leaf [LEAVES],
  output skt_pkg::key_t root
);
  import skt_pkg::*;

  localparam int P = 2 ** $clog2(LEAVES);

  // Heap-ordered registered nodes; node n combines nodes 2n and 2n+1, and
  // positions P and above are the leaves. Every tree level is registered.
  key_t node [1:P-1];

  for (genvar n = 1; n < P; n++) begin : g_node
    key_t lo;
    key_t hi;
    if (2 * n >= P) begin : g_leaf
      if (2 * n - P < LEAVES) begin : g_lo
        assign lo = leaf[2 * n - P];
      end else begin : g_lo0
        assign lo = '0;
      end
      if (2 * n + 1 - P < LEAVES) begin : g_hi
        assign hi = leaf[2 * n + 1 - P];
      end else begin : g_hi0
        assign hi = '0;
      end
    end else begin : g_inner
      assign lo = node[2 * n];
      assign hi = node[2 * n + 1];
    end
    always_ff @(posedge clk) begin
      node[n] <= lo | hi;
    end
  end

  assign root = node[1];

endmodule

// File: design/sorted_key_table.sv
// Channel  Direction  Handshake               Payload
// in       to block   in_valid / in_ready     action, key, index
// out      from block out_valid / out_ready   read_key, status, count
//
// One transfer is in flight at a time. An insert, a flagged request or an
// unused action shows its result in the cycle after the input transfer.
// An in-range lookup or remove registers the selected key, which then climbs a
// registered OR tree one level at a time. The key row itself inserts or
// removes in the transfer cycle. Synchronous reset empties the table at once;
// a stalled output holds the block, and in_ready stays low until it is taken.
module sorted_key_table #(
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 action,
  input  skt_pkg::key_t              key,
  input  skt_pkg::idx_t              index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output skt_pkg::key_t              read_key,
  output logic [1:0]                 status,
  output logic [skt_pkg::CNT_W-1:0]  count
);
  import skt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LEVELS = $clog2(DEPTH);
  localparam int WW = $clog2(LEVELS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] fill;
  logic [WW-1:0] wait_cnt;
  logic [1:0]    status_q;
  logic          use_tree;

  logic      take;
  logic      full;
  logic      idx_ok;
  skt_ctrl_t ctrl;
  key_t      root;

  key_t entry_w [DEPTH];
  logic less_w  [DEPTH];
  key_t tap_w   [DEPTH];

  assign in_ready = state == S_IDLE;
  assign take     = in_valid && in_ready;
  assign full     = fill == CW'(DEPTH);
  assign idx_ok   = 32'(index) < 32'(fill);

  assign ctrl.ins = take && (action == ACT_INSERT) && !full;
  assign ctrl.rem = take && (action == ACT_REMOVE) && idx_ok;
  assign ctrl.tap = take && ((action == ACT_LOOKUP) || (action == ACT_REMOVE));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    key_t left_entry;
    logic left_less;
    key_t right_entry;
    if (i == 0) begin : g_first
      assign left_entry = key;
      assign left_less  = 1'b1;
    end else begin : g_mid
      assign left_entry = entry_w[i-1];
      assign left_less  = less_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry_w[i];
    end else begin : g_next
      assign right_entry = entry_w[i+1];
    end
    skt_cell #(
      .INDEX(i),
      .CW   (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .key        (key),
      .index      (index),
      .fill       (fill),
      .left_entry (left_entry),
      .left_less  (left_less),
      .right_entry(right_entry),
      .entry      (entry_w[i]),
      .less       (less_w[i]),
      .tap        (tap_w[i])
    );
  end

  skt_or_tree #(
    .LEAVES(DEPTH)
  ) u_tree (
    .clk (clk),
    .leaf(tap_w),
    .root(root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      wait_cnt <= '0;
      status_q <= ST_OK;
      use_tree <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            status_q <= ST_OK;
            use_tree <= 1'b0;
            state    <= S_HOLD;
            case (action)
              ACT_INSERT: begin
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  fill <= fill + CW'(1);
                end
              end
              ACT_LOOKUP, ACT_REMOVE: begin
                if (!idx_ok) begin
                  status_q <= ST_RANGE;
                end else begin
                  use_tree <= 1'b1;
                  wait_cnt <= WW'(LEVELS - 1);
                  state    <= S_WALK;
                  if (action == ACT_REMOVE) begin
                    fill <= fill - CW'(1);
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          if (wait_cnt == '0) begin
            state <= S_HOLD;
          end else begin
            wait_cnt <= wait_cnt - WW'(1);
          end
        end
        S_HOLD: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = state == S_HOLD;
  assign read_key  = use_tree ? root : '0;
  assign status    = status_q;
  assign count     = CNT_W'(fill);

endmodule

// File: design/skt_checker.sv
module skt_checker #(
  parameter int DEPTH = 256
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input skt_pkg::key_t             read_key,
  input logic [1:0]                status,
  input logic [skt_pkg::CNT_W-1:0] count
);
  import skt_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_key) && $stable(status)
      && $stable(count))
    else $error("result changed while stalled");

  // Flagged requests never report a key.
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_RANGE) |-> read_key == '0)
    else $error("flagged result carries a key");

  // A full flag only appears when the table holds DEPTH keys.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count == CNT_W'(DEPTH))
    else $error("full flag with a table that is not full");

  // Only one transfer is in flight: after an input transfer, input is held off.
  a_one_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second input accepted while one is in flight");

endmodule

bind sorted_key_table skt_checker #(
  .DEPTH(DEPTH)
) u_skt_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .read_key (read_key),
  .status   (status),
  .count    (count)
);
